// ===== rtl/core/cbsi_pkg.sv =====
package cbsi_pkg;

    localparam int TAG_BITS = 8;
    localparam int N_BITS   = 4;
    localparam int WT_BITS  = 12;
    localparam int DEN_BITS = 16;

    localparam logic             REG_PPS   = 1'b0;
    localparam logic [N_BITS-1:0] PPS_RESET = 4'd10;

    typedef enum logic [1:0] {
        KIND_SEG,
        KIND_ONE,
        KIND_TWO
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [N_BITS-1:0]   n;
        logic [TAG_BITS-1:0] tag1;
        logic [TAG_BITS-1:0] tag2;
    } t_cmd;

endpackage

// ===== rtl/core/cbsi_fifo.sv =====
module cbsi_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/cbsi_front.sv =====
module cbsi_front
    import cbsi_pkg::*;
#(
    parameter int COORD_BITS = 24,
    localparam int PW = COORD_BITS + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [COORD_BITS-1:0]        i_x,
    input  logic [COORD_BITS-1:0]        i_y,
    input  logic [COORD_BITS-1:0]        i_z,
    input  logic [TAG_BITS-1:0]          i_tag,
    input  logic                         i_end,
    input  logic [N_BITS-1:0]            i_n,
    input  logic                         i_full,
    output logic                         o_push,
    output t_cmd                         o_cmd,
    output logic [2:0][3:0][PW-1:0]      o_pts
);

    logic [2:0][2:0][COORD_BITS-1:0] r_h;
    logic [2:0][TAG_BITS-1:0]        r_ht;
    logic [2:0]                      r_seen;
    logic [2:0]                      n_seen;
    logic                            acc;
    logic [2:0][COORD_BITS-1:0]      in_c;

    assign o_ready = !i_full;
    assign acc     = i_valid && !i_full;
    assign in_c    = {i_z, i_y, i_x};

    always_comb begin
        logic signed [PW-1:0] h0;
        logic signed [PW-1:0] h1;
        logic signed [PW-1:0] h2;
        o_cmd.kind = KIND_SEG;
        o_cmd.n    = i_n;
        o_cmd.tag1 = r_ht[1];
        o_cmd.tag2 = r_ht[0];
        o_push     = 1'b0;
        n_seen     = 3'd0;
        for (int c = 0; c < 3; c++) begin
            h0 = PW'($signed(r_h[0][c]));
            h1 = PW'($signed(r_h[1][c]));
            h2 = PW'($signed(r_h[2][c]));
            o_pts[c][0] = h2;
            o_pts[c][1] = h1;
            o_pts[c][2] = h0;
            o_pts[c][3] = PW'($signed(in_c[c]));
            if (!i_end) begin
                if (r_seen == 3'd2) begin
                    o_pts[c][0] = (h1 <<< 1) - h0;
                end
                if (r_seen == 3'd0) begin
                    o_pts[c][2] = PW'($signed(in_c[c]));
                end
            end else begin
                o_pts[c][3] = (h0 <<< 1) - h1;
            end
        end
        if (!i_end) begin
            n_seen = (r_seen == 3'd4) ? 3'd4 : r_seen + 3'd1;
            if (n_seen == 3'd1) begin
                o_cmd.kind = KIND_ONE;
                o_cmd.tag2 = i_tag;
                o_push     = acc;
            end else if (n_seen != 3'd2) begin
                o_push = acc && (i_n != '0);
            end
        end else begin
            if (r_seen >= 3'd3) begin
                o_push = acc && (i_n != '0);
            end else if (r_seen == 3'd2) begin
                o_cmd.kind = KIND_TWO;
                o_push     = acc;
            end else if (r_seen == 3'd1) begin
                o_cmd.kind = KIND_ONE;
                o_push     = acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 3'd0;
        end else if (acc) begin
            r_seen <= n_seen;
            if (!i_end) begin
                r_h[2]  <= r_h[1];
                r_h[1]  <= r_h[0];
                r_h[0]  <= in_c;
                r_ht[2] <= r_ht[1];
                r_ht[1] <= r_ht[0];
                r_ht[0] <= i_tag;
            end
        end
    end

endmodule

// ===== rtl/core/cbsi_lane.sv =====
module cbsi_lane
    import cbsi_pkg::*;
#(
    parameter int COORD_BITS = 24,
    localparam int CW = COORD_BITS + 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [3:0][CW-1:0]          i_coef,
    input  logic [3:0][WT_BITS-1:0]     i_wt,
    input  logic [DEN_BITS-1:0]         i_den,
    output logic                        o_done,
    output logic [COORD_BITS-1:0]       o_res
);

    localparam int MW   = COORD_BITS + 22;
    localparam int NW   = COORD_BITS + 24;
    localparam int QB   = COORD_BITS + (COORD_BITS % 2);
    localparam int XW   = QB + DEN_BITS;
    localparam int CNTW = $clog2(QB);

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL,
        L_PREP,
        L_DIV,
        L_DONE
    } t_state;

    t_state                   r_state;
    logic [CNTW-1:0]          r_cnt;
    logic signed [MW-1:0]     r_acc;
    logic [DEN_BITS-1:0]      r_rem;
    logic [QB-1:0]            r_dvd;
    logic [QB-1:0]            r_q;
    logic [COORD_BITS-1:0]    r_res;

    logic [DEN_BITS-1:0]      d2;
    logic signed [CW+WT_BITS:0] prod;
    logic signed [NW-1:0]     num2;
    logic signed [NW-1:0]     thr;
    logic signed [NW-1:0]     ofs;
    logic [XW-1:0]            ux;
    logic                     hi;
    logic                     lo;
    logic [DEN_BITS-1:0]      n_rem;
    logic [QB-1:0]            n_dvd;
    logic [QB-1:0]            n_q;

    assign d2   = {i_den[DEN_BITS-2:0], 1'b0};
    assign prod = $signed(i_coef[r_cnt[1:0]]) * $signed({1'b0, i_wt[r_cnt[1:0]]});
    assign num2 = (NW'(r_acc) <<< 1) + NW'($signed({1'b0, i_den}));
    assign thr  = NW'($signed({1'b0, d2})) <<< (COORD_BITS - 1);
    assign hi   = (num2 >= thr);
    assign lo   = (num2 < -thr);
    assign ofs  = num2 + thr;
    assign ux   = XW'(ofs[COORD_BITS+15:0]);

    always_comb begin
        logic [DEN_BITS-1:0] rem;
        logic [QB-1:0]       dv;
        logic [QB-1:0]       q;
        logic [DEN_BITS:0]   t;
        rem = r_rem;
        dv  = r_dvd;
        q   = r_q;
        for (int i = 0; i < 2; i++) begin
            t  = {rem, dv[QB-1]};
            dv = {dv[QB-2:0], 1'b0};
            if (t >= {1'b0, d2}) begin
                rem = DEN_BITS'(t - {1'b0, d2});
                q   = {q[QB-2:0], 1'b1};
            end else begin
                rem = t[DEN_BITS-1:0];
                q   = {q[QB-2:0], 1'b0};
            end
        end
        n_rem = rem;
        n_dvd = dv;
        n_q   = q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                L_IDLE, L_DONE: begin
                    if (i_start) begin
                        r_state <= L_MUL;
                        r_cnt   <= '0;
                        r_acc   <= '0;
                    end
                end
                L_MUL: begin
                    r_acc <= r_acc + MW'(prod);
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[1:0] == 2'd3) begin
                        r_state <= L_PREP;
                    end
                end
                L_PREP: begin
                    r_cnt <= '0;
                    r_q   <= '0;
                    if (hi) begin
                        r_res   <= {1'b0, {(COORD_BITS-1){1'b1}}};
                        r_state <= L_DONE;
                    end else if (lo) begin
                        r_res   <= {1'b1, {(COORD_BITS-1){1'b0}}};
                        r_state <= L_DONE;
                    end else begin
                        r_rem   <= ux[XW-1 -: DEN_BITS];
                        r_dvd   <= ux[QB-1:0];
                        r_state <= L_DIV;
                    end
                end
                L_DIV: begin
                    r_rem <= n_rem;
                    r_dvd <= n_dvd;
                    r_q   <= n_q;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(QB/2 - 1)) begin
                        r_res   <= {~n_q[COORD_BITS-1], n_q[COORD_BITS-2:0]};
                        r_state <= L_DONE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == L_DONE);
    assign o_res  = r_res;

endmodule

// ===== rtl/core/cbsi_back.sv =====
module cbsi_back
    import cbsi_pkg::*;
#(
    parameter int COORD_BITS = 24,
    localparam int PW = COORD_BITS + 2,
    localparam int CW = COORD_BITS + 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic [2:0][3:0][PW-1:0]   i_pts,
    input  logic                      i_empty,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [COORD_BITS-1:0]     o_x,
    output logic [COORD_BITS-1:0]     o_y,
    output logic [COORD_BITS-1:0]     o_z,
    output logic [TAG_BITS-1:0]       o_tag,
    output logic                      o_last
);

    typedef enum logic [2:0] {
        B_IDLE,
        B_SET1,
        B_SET2,
        B_GO,
        B_WAIT,
        B_COPY
    } t_state;

    t_state                        r_state;
    t_cmd                          r_cmd;
    logic [2:0][3:0][PW-1:0]       r_pts;
    logic [2:0][3:0][CW-1:0]       r_coef;
    logic [2:0][3:0][CW-1:0]       coef_n;
    logic [N_BITS-1:0]             r_k;
    logic                          r_sub;
    logic [7:0]                    r_nn;
    logic [7:0]                    r_jj;
    logic [7:0]                    r_jn;
    logic [3:0][WT_BITS-1:0]       r_w;
    logic [DEN_BITS-1:0]           r_den;
    logic                          r_ov;
    logic [COORD_BITS-1:0]         r_ox;
    logic [COORD_BITS-1:0]         r_oy;
    logic [COORD_BITS-1:0]         r_oz;
    logic [TAG_BITS-1:0]           r_otag;
    logic                          r_olast;

    logic [N_BITS-1:0]             j;
    logic                          start;
    logic [2:0]                    done;
    logic [2:0][COORD_BITS-1:0]    res;
    logic                          ofree;
    logic                          ov_set;
    logic                          seg_last;

    assign j        = r_k + 1'b1;
    assign start    = (r_state == B_GO);
    assign ofree    = !r_ov || i_ready;
    assign ov_set   = ((r_state == B_WAIT) && (&done) && ofree) ||
                      ((r_state == B_COPY) && ofree);
    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign seg_last = (r_k == r_cmd.n - 1'b1);

    // basis coefficients per coordinate
    always_comb begin
        logic signed [CW-1:0] e0;
        logic signed [CW-1:0] e1;
        logic signed [CW-1:0] e2;
        logic signed [CW-1:0] e3;
        for (int c = 0; c < 3; c++) begin
            e0 = CW'($signed(i_pts[c][0]));
            e1 = CW'($signed(i_pts[c][1]));
            e2 = CW'($signed(i_pts[c][2]));
            e3 = CW'($signed(i_pts[c][3]));
            coef_n[c][0] = -e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3;
            coef_n[c][1] = (e0 <<< 1) + e0 - (e1 <<< 2) - (e1 <<< 1) + (e2 <<< 1) + e2;
            coef_n[c][2] = (e2 <<< 1) + e2 - (e0 <<< 1) - e0;
            coef_n[c][3] = e0 + (e1 <<< 2) + e2;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
        cbsi_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (start),
            .i_coef  (r_coef[c]),
            .i_wt    (r_w),
            .i_den   (r_den),
            .o_done  (done[c]),
            .o_res   (res[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_ov <= ov_set || (r_ov && !i_ready);
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_cmd;
                        r_pts   <= i_pts;
                        r_coef  <= coef_n;
                        r_k     <= '0;
                        r_sub   <= 1'b0;
                        r_state <= (i_cmd.kind == KIND_SEG) ? B_SET1 : B_COPY;
                    end
                end
                B_SET1: begin
                    r_nn    <= {4'b0, r_cmd.n} * {4'b0, r_cmd.n};
                    r_jj    <= {4'b0, j} * {4'b0, j};
                    r_jn    <= {4'b0, j} * {4'b0, r_cmd.n};
                    r_state <= B_SET2;
                end
                B_SET2: begin
                    r_w[0]  <= {4'b0, r_jj} * {8'b0, j};
                    r_w[1]  <= {4'b0, r_jj} * {8'b0, r_cmd.n};
                    r_w[2]  <= {4'b0, r_jn} * {8'b0, r_cmd.n};
                    r_w[3]  <= {4'b0, r_nn} * {8'b0, r_cmd.n};
                    r_den   <= {8'b0, r_nn} * {12'b0, r_cmd.n} * 16'd6;
                    r_state <= B_GO;
                end
                B_GO: begin
                    r_state <= B_WAIT;
                end
                B_WAIT: begin
                    if ((&done) && ofree) begin
                        r_ox    <= res[0];
                        r_oy    <= res[1];
                        r_oz    <= res[2];
                        r_otag  <= (r_k <= (r_cmd.n >> 1)) ? r_cmd.tag1 : r_cmd.tag2;
                        r_olast <= seg_last;
                        if (seg_last) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_k     <= j;
                            r_state <= B_SET1;
                        end
                    end
                end
                B_COPY: begin
                    if (ofree) begin
                        if (r_cmd.kind == KIND_ONE || r_sub) begin
                            r_ox    <= r_pts[0][2][COORD_BITS-1:0];
                            r_oy    <= r_pts[1][2][COORD_BITS-1:0];
                            r_oz    <= r_pts[2][2][COORD_BITS-1:0];
                            r_otag  <= r_cmd.tag2;
                            r_olast <= 1'b1;
                            r_state <= B_IDLE;
                        end else begin
                            r_ox    <= r_pts[0][1][COORD_BITS-1:0];
                            r_oy    <= r_pts[1][1][COORD_BITS-1:0];
                            r_oz    <= r_pts[2][1][COORD_BITS-1:0];
                            r_otag  <= r_cmd.tag1;
                            r_olast <= 1'b0;
                            r_sub   <= 1'b1;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_x     = r_ox;
    assign o_y     = r_oy;
    assign o_z     = r_oz;
    assign o_tag   = r_otag;
    assign o_last  = r_olast;

endmodule

// ===== rtl/core/cubic_bspline_point_interpolator.sv =====
// Uniform cubic B-spline interpolator for a stream of 3D points.
// Input words on s_axis: a point (x, y, z, tag) or, with tuser high, an
// end-of-chain marker. Output words on m_axis carry the interpolated points;
// tlast marks the final word caused by an input word.
// The first point of a chain is echoed, the second gives nothing, every later
// point gives one segment of N points, and the end marker closes the chain
// with a last segment (or copies out a chain of one or two points).
// N is set through the APB register at address 0 and capped at MAX_STEPS;
// the user must write it only while the block is idle, which the block itself
// does not enforce. Each segment point is made by setting up the step weights,
// then a multiply-accumulate over the four weights and a two-bit-per-cycle
// divider in each of three coordinate lanes.
// A two-entry queue between the classifier and the segment engine lets input
// words be taken while the engine works; s_axis_tready drops when it fills.
// When m_axis_tready is low the output word holds and the engine waits.
// Reset is synchronous; it clears the chain history, the queue and the
// engine, and sets N to 10.
module cubic_bspline_point_interpolator
    import cbsi_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int MAX_STEPS  = 10,
    localparam int DW = ((3*COORD_BITS + TAG_BITS + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [DW-1:0] s_axis_tdata,   // pos_x, pos_y, pos_z, point_tag
    input  logic          s_axis_tuser,   // chain_end
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [DW-1:0] m_axis_tdata,   // out_x, out_y, out_z, out_tag
    output logic          m_axis_tlast,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int PW = COORD_BITS + 2;
    localparam int QW = $bits(t_cmd) + 12*PW;

    logic [N_BITS-1:0]           r_pps;
    logic [N_BITS-1:0]           n_eff;
    logic                        push;
    logic                        full;
    logic                        pop;
    logic                        empty;
    t_cmd                        f_cmd;
    logic [2:0][3:0][PW-1:0]     f_pts;
    logic [QW-1:0]               q_out;
    logic [COORD_BITS-1:0]       ox;
    logic [COORD_BITS-1:0]       oy;
    logic [COORD_BITS-1:0]       oz;
    logic [TAG_BITS-1:0]         otag;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PPS) ? {28'b0, r_pps} : 32'b0;
    assign n_eff  = (int'(r_pps) > MAX_STEPS) ? N_BITS'(MAX_STEPS) : r_pps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pps <= PPS_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_PPS) begin
            r_pps <= pwdata[N_BITS-1:0];
        end
    end

    cbsi_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_x     (s_axis_tdata[COORD_BITS-1:0]),
        .i_y     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_z     (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_tag   (s_axis_tdata[3*COORD_BITS+TAG_BITS-1:3*COORD_BITS]),
        .i_end   (s_axis_tuser),
        .i_n     (n_eff),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (f_cmd),
        .o_pts   (f_pts)
    );

    cbsi_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_pts, f_cmd}),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_out)
    );

    cbsi_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (t_cmd'(q_out[$bits(t_cmd)-1:0])),
        .i_pts   (q_out[QW-1:$bits(t_cmd)]),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_x     (ox),
        .o_y     (oy),
        .o_z     (oz),
        .o_tag   (otag),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = DW'({otag, oz, oy, ox});

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import cbsi_pkg::*;

    localparam int CB    = 24;
    localparam int DW    = 80;
    localparam int LIMIT = 600000;
    localparam int SETTLE = 300;

    typedef struct {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [CB-1:0] z;
        logic [7:0]    tag;
        logic          last;
    } t_spline_word;

    class spline_scoreboard;
        longint       rx[4];
        longint       ry[4];
        longint       rz[4];
        logic [7:0]   rt[4];
        longint       cp[3][4];
        int           seen;
        int           newest;
        int           steps;
        int           errors;
        t_spline_word pending_q[$];

        function new();
            seen = 0;
            newest = 3;
            steps = 10;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void load(int i, int slot);
            cp[0][i] = rx[slot & 3];
            cp[1][i] = ry[slot & 3];
            cp[2][i] = rz[slot & 3];
        endfunction

        function void push(longint x, longint y, longint z, logic [7:0] tag, logic last);
            t_spline_word w;
            w.x = x[CB-1:0];
            w.y = y[CB-1:0];
            w.z = z[CB-1:0];
            w.tag = tag;
            w.last = last;
            pending_q.push_back(w);
        endfunction

        function longint round_sat(longint num, longint den);
            longint n2;
            longint d2;
            longint q;
            n2 = 2 * num + den;
            d2 = 2 * den;
            q = n2 / d2;
            if ((n2 % d2) != 0 && n2 < 0) q--;
            if (q > 64'sd8388607) q = 64'sd8388607;
            if (q < -64'sd8388608) q = -64'sd8388608;
            return q;
        endfunction

        function void emit_segment(logic [7:0] t1, logic [7:0] t2);
            longint n;
            longint den;
            longint j;
            longint a;
            longint b;
            longint c;
            longint d;
            longint v[3];
            n = (steps > 10) ? 10 : steps;
            den = 6 * n * n * n;
            for (int k = 0; k < n; k++) begin
                j = k + 1;
                for (int ax = 0; ax < 3; ax++) begin
                    a = -cp[ax][0] + 3 * cp[ax][1] - 3 * cp[ax][2] + cp[ax][3];
                    b = 3 * cp[ax][0] - 6 * cp[ax][1] + 3 * cp[ax][2];
                    c = 3 * cp[ax][2] - 3 * cp[ax][0];
                    d = cp[ax][0] + 4 * cp[ax][1] + cp[ax][2];
                    v[ax] = round_sat(a * j * j * j + b * j * j * n + c * j * n * n
                                      + d * n * n * n, den);
                end
                push(v[0], v[1], v[2], (k <= n / 2) ? t1 : t2, (k + 1 == n));
            end
        endfunction

        function void note_input(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-1:0] z,
                                 logic [7:0] tag, logic chain_end);
            int s;
            s = newest;
            if (!chain_end) begin
                if (seen < 4) seen++;
                s = (s + 1) & 3;
                newest = s;
                rx[s] = longint'($signed(x));
                ry[s] = longint'($signed(y));
                rz[s] = longint'($signed(z));
                rt[s] = tag;
                if (seen == 1) begin
                    push(rx[s], ry[s], rz[s], rt[s], 1'b1);
                end else if (seen >= 3) begin
                    load(3, s);
                    load(2, s + 3);
                    load(1, s + 2);
                    if (seen == 3) begin
                        for (int ax = 0; ax < 3; ax++) cp[ax][0] = 2 * cp[ax][1] - cp[ax][2];
                    end else begin
                        load(0, s + 1);
                    end
                    emit_segment(rt[(s + 2) & 3], rt[(s + 3) & 3]);
                end
            end else if (seen > 2) begin
                load(2, s);
                load(1, s + 3);
                load(0, s + 2);
                for (int ax = 0; ax < 3; ax++) cp[ax][3] = 2 * cp[ax][2] - cp[ax][1];
                emit_segment(rt[(s + 3) & 3], rt[s]);
                seen = 0;
            end else begin
                if (seen == 2) begin
                    push(rx[(s + 3) & 3], ry[(s + 3) & 3], rz[(s + 3) & 3], rt[(s + 3) & 3],
                         1'b0);
                    push(rx[s], ry[s], rz[s], rt[s], 1'b1);
                end else if (seen == 1) begin
                    push(rx[s], ry[s], rz[s], rt[s], 1'b1);
                end
                seen = 0;
                newest = 3;
            end
        endfunction

        task check_word(logic [DW-1:0] data, logic last);
            t_spline_word e;
            if (pending_q.size() == 0) begin
                report($sformatf("word with nothing expected: %h", data));
            end else begin
                e = pending_q.pop_front();
                if (data[CB-1:0] !== e.x)
                    report($sformatf("x %h, expected %h", data[CB-1:0], e.x));
                if (data[2*CB-1:CB] !== e.y)
                    report($sformatf("y %h, expected %h", data[2*CB-1:CB], e.y));
                if (data[3*CB-1:2*CB] !== e.z)
                    report($sformatf("z %h, expected %h", data[3*CB-1:2*CB], e.z));
                if (data[3*CB+7:3*CB] !== e.tag)
                    report($sformatf("tag %h, expected %h", data[3*CB+7:3*CB], e.tag));
                if (last !== e.last)
                    report($sformatf("tlast %b, expected %b", last, e.last));
            end
        endtask
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata;   // pos_x, pos_y, pos_z, point_tag
    logic          s_axis_tuser;   // chain_end
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [DW-1:0] m_axis_tdata;   // out_x, out_y, out_z, out_tag
    logic          m_axis_tlast;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    spline_scoreboard sb;
    int  cycles;
    bit  no_gaps;
    int  points_sent;

    cubic_bspline_point_interpolator uut (.*);

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("cubic_bspline_point_interpolator test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tlast);
    end

    // result side: random stall before each word, unless no_gaps is set
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            m_axis_tready = 1'b0;
            repeat (no_gaps ? 0 : $urandom_range(0, 13)) @(negedge i_clk);
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    function automatic logic [CB-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return CB'($signed($urandom_range(0, 8191)) - 4096);
            default: return CB'($urandom);
        endcase
    endfunction

    task automatic send_word(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-1:0] z,
                             logic [7:0] tag, logic chain_end);
        repeat (no_gaps ? 0 : $urandom_range(0, 13)) @(negedge i_clk);
        s_axis_tdata = {tag, z, y, x};
        s_axis_tuser = chain_end;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(x, y, z, tag, chain_end);
        if (!chain_end) points_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_point();
        send_word(pick_coord(), pick_coord(), pick_coord(), 8'($urandom), 1'b0);
    endtask

    task automatic send_end();
        send_word(CB'($urandom), CB'($urandom), CB'($urandom), 8'($urandom), 1'b1);
    endtask

    task automatic drain();
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_steps(logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 3'(REG_PPS) << 2;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.steps = int'(value[N_BITS-1:0]);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic random_chain();
        int len;
        if ($urandom_range(0, 9) == 0) send_end();
        len = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 2) : $urandom_range(3, 7);
        repeat (len) send_point();
        send_end();
    endtask

    initial begin
        int steps_list[6];
        steps_list = '{1, 15, 0, 4, 7, 2};
        sb = new();
        no_gaps = 1'b0;
        points_sent = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: saturating extremes, short chains, empty end, long chain
        send_word(24'h7fffff, 24'h800000, 24'h7fffff, 8'h00, 1'b0);
        send_word(24'h800000, 24'h7fffff, 24'h800000, 8'hff, 1'b0);
        send_word(24'h7fffff, 24'h800000, 24'h7fffff, 8'h00, 1'b0);
        send_word(24'h800000, 24'h7fffff, 24'h800000, 8'hff, 1'b0);
        send_end();
        send_end();
        send_word(24'h000100, 24'hffff00, 24'h000000, 8'h5a, 1'b0);
        send_end();
        send_word(24'h123456, 24'hedcba9, 24'h000001, 8'ha5, 1'b0);
        send_word(24'hfffffe, 24'h000002, 24'h7fffff, 8'h3c, 1'b0);
        send_end();
        drain();
        write_steps(32'd1);
        no_gaps = 1'b1;
        repeat (6) send_point();
        send_end();
        no_gaps = 1'b0;
        drain();

        foreach (steps_list[i]) begin
            write_steps(steps_list[i]);
            no_gaps = (i % 3 == 1);
            repeat (2) random_chain();
            drain();
        end
        write_steps(32'd10);
        while (points_sent < 85) random_chain();
        drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("cubic_bspline_point_interpolator test passed");
        end else begin
            $display("cubic_bspline_point_interpolator test failed");
        end
        $finish;
    end

endmodule

// ===== cubic_bspline_point_interpolator.f =====
rtl/core/cbsi_pkg.sv
rtl/core/cbsi_fifo.sv
rtl/core/cbsi_front.sv
rtl/core/cbsi_lane.sv
rtl/core/cbsi_back.sv
rtl/core/cubic_bspline_point_interpolator.sv
dv/testbench.sv
